>>> src/mpps_pkg.sv
// ----------------------------------------------------------------------------
// mpps_pkg: shared types and constants for the motor position PID step
// Widths, register indexes, reset values, controller state codes and the
// command and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mpps_pkg;

  // Field widths
  localparam int SETPOINT_W   = 8;
  localparam int ENCODER_W    = 16;
  localparam int MAGNITUDE_W  = 7;
  localparam int FULL_SCALE_W = 15;
  localparam int GAIN_W       = 10;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 15;

  // Internal widths
  localparam int DEN_W      = 8;   // full_scale / 255 is at most 128
  localparam int ERR_W      = 17;  // setpoint - position, position - previous
  localparam int INTEGRAL_W = 32;
  localparam int PROD_W     = INTEGRAL_W + GAIN_W + 1;
  localparam int SUM_W      = PROD_W + 2;

  // Deadband threshold on |error|
  localparam logic [ERR_W-1:0] DEADBAND = ERR_W'(7);

  // Divider iterations, one quotient bit each
  localparam int DIV_STEPS = ENCODER_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_RST = FULL_SCALE_W'(10000);
  localparam logic [GAIN_W-1:0]       GAIN_P_RST     = GAIN_W'(230);
  localparam logic [GAIN_W-1:0]       GAIN_I_RST     = GAIN_W'(38);
  localparam logic [GAIN_W-1:0]       GAIN_D_RST     = GAIN_W'(15);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FULL_SCALE = 2'd0,
    REG_GAIN_P     = 2'd1,
    REG_GAIN_I     = 2'd2,
    REG_GAIN_D     = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_CALC   = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    SEL_P    = 2'd0,
    SEL_I    = 2'd1,
    SEL_D    = 2'd2,
    SEL_NONE = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // capture input item, set up divider
    logic     div_step;  // one restoring division step
    logic     calc;      // position, error, integral, derivative
    logic     mul_en;    // register product of selected term
    mul_sel_t mul_sel;
    logic     acc_load;  // sum <= product
    logic     acc_add;   // sum <= sum + product
    logic     commit;    // form result, update deadband state
  } cmd_t;

  typedef struct packed {
    logic div_done;      // last division step is under way
  } status_t;

endpackage

>>> src/mpps_in_if.sv
// ----------------------------------------------------------------------------
// mpps_in_if: input channel of the motor position PID step
// Valid/ready channel carrying one control tick: setpoint and encoder count.
// ----------------------------------------------------------------------------
interface mpps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mpps_pkg::SETPOINT_W-1:0]      setpoint;
  logic signed [mpps_pkg::ENCODER_W-1:0] encoder_count;

  modport source (output valid, output setpoint, output encoder_count, input ready);
  modport sink   (input valid, input setpoint, input encoder_count, output ready);
endinterface

>>> src/mpps_out_if.sv
// ----------------------------------------------------------------------------
// mpps_out_if: output channel of the motor position PID step
// Valid/ready channel carrying one drive result per control tick.
// ----------------------------------------------------------------------------
interface mpps_out_if;
  logic                             valid;
  logic                             ready;
  logic [mpps_pkg::MAGNITUDE_W-1:0] drive_magnitude;
  logic                             drive_right;
  logic                             in_deadband;

  modport source (output valid, output drive_magnitude, output drive_right,
                  output in_deadband, input ready);
  modport sink   (input valid, input drive_magnitude, input drive_right,
                  input in_deadband, output ready);
endinterface

>>> src/mpps_ctrl.sv
// ----------------------------------------------------------------------------
// mpps_ctrl: sequencer for the motor position PID step
// Walks one item through divide, error update, three multiplies and commit.
// ----------------------------------------------------------------------------
module mpps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mpps_pkg::status_t   status,
  output mpps_pkg::cmd_t      cmd
);

  mpps_pkg::state_t state;
  mpps_pkg::state_t state_next;
  logic [1:0]       step;
  logic [1:0]       step_next;
  logic             out_valid_next;
  logic             can_write;

  assign in_ready  = (state == mpps_pkg::ST_IDLE);
  assign can_write = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    cmd.mul_sel    = mpps_pkg::SEL_NONE;
    case (state)
      mpps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mpps_pkg::ST_DIVIDE;
        end
      end
      mpps_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = mpps_pkg::ST_CALC;
        end
      end
      mpps_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        step_next  = 2'd0;
        state_next = mpps_pkg::ST_MULT;
      end
      mpps_pkg::ST_MULT: begin
        step_next = step + 2'd1;
        case (step)
          2'd0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mpps_pkg::SEL_P;
          end
          2'd1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = mpps_pkg::SEL_I;
            cmd.acc_load = 1'b1;
          end
          2'd2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mpps_pkg::SEL_D;
            cmd.acc_add = 1'b1;
          end
          default: begin
            cmd.acc_add = 1'b1;
            state_next  = mpps_pkg::ST_WRITE;
          end
        endcase
      end
      mpps_pkg::ST_WRITE: begin
        // hold until the output register is free
        if (can_write) begin
          cmd.commit = 1'b1;
          state_next = mpps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpps_pkg::ST_IDLE;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/mpps_dp.sv
// ----------------------------------------------------------------------------
// mpps_dp: datapath for the motor position PID step
// Config registers, restoring divider, PID state, shared multiplier,
// accumulator and the output payload register.
// ----------------------------------------------------------------------------
module mpps_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [mpps_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [mpps_pkg::SETPOINT_W-1:0]       setpoint,
  input  logic signed [mpps_pkg::ENCODER_W-1:0] encoder_count,
  input  mpps_pkg::cmd_t                        cmd,
  output mpps_pkg::status_t                     status,
  output logic [mpps_pkg::MAGNITUDE_W-1:0]      drive_magnitude,
  output logic                                  drive_right,
  output logic                                  in_deadband
);

  localparam int ENC_W = mpps_pkg::ENCODER_W;
  localparam int ERR_W = mpps_pkg::ERR_W;
  localparam int INT_W = mpps_pkg::INTEGRAL_W;
  localparam int DEN_W = mpps_pkg::DEN_W;
  localparam int SUM_W = mpps_pkg::SUM_W;
  localparam int PRD_W = mpps_pkg::PROD_W;
  localparam int GN_W  = mpps_pkg::GAIN_W;
  localparam int SP_W  = mpps_pkg::SETPOINT_W;
  localparam int MAG_W = mpps_pkg::MAGNITUDE_W;
  localparam int FS_W  = mpps_pkg::FULL_SCALE_W;

  // configuration registers
  logic [FS_W-1:0] full_scale;
  logic [GN_W-1:0] gain_p;
  logic [GN_W-1:0] gain_i;
  logic [GN_W-1:0] gain_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= mpps_pkg::FULL_SCALE_RST;
      gain_p     <= mpps_pkg::GAIN_P_RST;
      gain_i     <= mpps_pkg::GAIN_I_RST;
      gain_d     <= mpps_pkg::GAIN_D_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mpps_pkg::REG_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
        mpps_pkg::REG_GAIN_P:     gain_p     <= cfg_data[GN_W-1:0];
        mpps_pkg::REG_GAIN_I:     gain_i     <= cfg_data[GN_W-1:0];
        mpps_pkg::REG_GAIN_D:     gain_d     <= cfg_data[GN_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor: full_scale / 255 as (x + (x >> 8) + 1) >> 8, zero forced to one
  logic [FS_W:0]    den_raw;
  logic [DEN_W-1:0] den_w;

  always_comb begin
    den_raw = ({1'b0, full_scale} + ({1'b0, full_scale} >> 8) + (FS_W+1)'(1)) >> 8;
    den_w   = (den_raw == '0) ? DEN_W'(1) : den_raw[DEN_W-1:0];
  end

  // divider registers
  logic [SP_W-1:0]                      sp_q;
  logic                                 neg_q;
  logic [ENC_W-1:0]                     quo;
  logic [DEN_W-1:0]                     rem;
  logic [DEN_W-1:0]                     den_q;
  logic [mpps_pkg::DIV_CNT_W-1:0]       div_cnt;
  logic [DEN_W:0]                       trial;
  logic                                 fits;
  logic [ENC_W-1:0]                     enc_abs;

  assign enc_abs = encoder_count[ENC_W-1] ? ENC_W'(-encoder_count) : encoder_count;
  assign trial   = {rem, quo[ENC_W-1]};
  assign fits    = trial >= {1'b0, den_q};
  assign status.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sp_q    <= setpoint;
      neg_q   <= encoder_count[ENC_W-1];
      quo     <= enc_abs;
      rem     <= '0;
      den_q   <= den_w;
      div_cnt <= mpps_pkg::DIV_CNT_W'(mpps_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      quo     <= {quo[ENC_W-2:0], fits};
      rem     <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // error, integral and derivative
  logic signed [ERR_W-1:0] pos_w;
  logic signed [ERR_W-1:0] err_w;
  logic signed [ERR_W-1:0] deriv_w;
  logic signed [INT_W:0]   int_sum;
  logic signed [INT_W-1:0] int_sat;
  logic signed [ERR_W-1:0] err_q;
  logic signed [ERR_W-1:0] deriv_q;
  logic signed [INT_W-1:0] integral;
  logic signed [ENC_W-1:0] last_position;
  logic                    last_dir;

  always_comb begin
    pos_w   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    err_w   = $signed({{(ERR_W-SP_W){1'b0}}, sp_q}) - pos_w;
    deriv_w = pos_w - $signed({last_position[ENC_W-1], last_position});
    int_sum = $signed({integral[INT_W-1], integral})
            + $signed({{(INT_W+1-ERR_W){err_w[ERR_W-1]}}, err_w});
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_sat = int_sum[INT_W] ? $signed({1'b1, {(INT_W-1){1'b0}}})
                               : $signed({1'b0, {(INT_W-1){1'b1}}});
    end else begin
      int_sat = int_sum[INT_W-1:0];
    end
  end

  // shared multiplier and accumulator
  logic signed [INT_W-1:0] mul_a;
  logic signed [GN_W:0]    mul_b;
  logic signed [PRD_W-1:0] prod;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    case (cmd.mul_sel)
      mpps_pkg::SEL_P: begin
        mul_a = $signed({{(INT_W-ERR_W){err_q[ERR_W-1]}}, err_q});
        mul_b = $signed({1'b0, gain_p});
      end
      mpps_pkg::SEL_I: begin
        mul_a = integral;
        mul_b = $signed({1'b0, gain_i});
      end
      mpps_pkg::SEL_D: begin
        mul_a = $signed({{(INT_W-ERR_W){deriv_q[ERR_W-1]}}, deriv_q});
        mul_b = $signed({1'b0, gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc_load) begin
      sum <= SUM_W'(prod);
    end else if (cmd.acc_add) begin
      sum <= sum + SUM_W'(prod);
    end
  end

  // result
  logic [SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0] mag_w;
  logic [ERR_W-1:0] abs_err;
  logic             dead_w;

  always_comb begin
    abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    if (abs_sum[SUM_W-1:MAG_W+8] != '0) begin
      mag_w = '1;
    end else begin
      mag_w = abs_sum[MAG_W+7:8];
    end
    abs_err = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
    dead_w  = abs_err < mpps_pkg::DEADBAND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral      <= '0;
      last_position <= '0;
      last_dir      <= 1'b0;
    end else if (cmd.calc) begin
      integral      <= int_sat;
      last_position <= pos_w[ENC_W-1:0];
    end else if (cmd.commit) begin
      if (dead_w) begin
        integral <= '0;
      end else begin
        // right when the position lies below the setpoint
        last_dir <= (err_q > 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      err_q   <= err_w;
      deriv_q <= deriv_w;
    end
    if (cmd.commit) begin
      drive_magnitude <= dead_w ? '0 : mag_w;
      drive_right     <= dead_w ? last_dir : (err_q > 0);
      in_deadband     <= dead_w;
    end
  end

endmodule

>>> src/motor_position_pid_step.sv
// ----------------------------------------------------------------------------
// motor_position_pid_step: one control tick of a motor position PID loop
// Scales the encoder, updates error, integral and derivative, and returns a
// saturated drive magnitude, direction and deadband flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   one transaction per control tick: setpoint, encoder_count.
//   out_ch (source) one transaction per tick: drive_magnitude, drive_right,
//                   in_deadband.
//   cfg_wr_en/cfg_index/cfg_data write full scale (0) and the Q8 gains
//   P (1), I (2), D (3); write only while no tick is in flight.
// Sequence: the 16-step restoring divider scales the encoder, and the single
//   shared multiplier is used once per gain term, before out_ch.valid rises.
// Input: in_ch.ready is high only between items; a new tick is taken only
//   after the last one is committed. The next input is taken while a
//   finished result still waits in the output register.
// Reset: rst clears the integral, previous position and direction (left),
//   restores the register defaults and drops any pending result.
// Stall: when out_ch.ready is low, hold the result; the following tick
//   finishes its computation and then waits for the output register.
// ----------------------------------------------------------------------------
module motor_position_pid_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [mpps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]  cfg_data,
  mpps_in_if.sink                          in_ch,
  mpps_out_if.source                       out_ch
);

  mpps_pkg::cmd_t    cmd;
  mpps_pkg::status_t status;

  // sequence the tick: divide, update state, multiply-accumulate, commit
  mpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, PID state and output payload
  mpps_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .setpoint        (in_ch.setpoint),
    .encoder_count   (in_ch.encoder_count),
    .cmd             (cmd),
    .status          (status),
    .drive_magnitude (out_ch.drive_magnitude),
    .drive_right     (out_ch.drive_right),
    .in_deadband     (out_ch.in_deadband)
  );

endmodule

>>> src/mpps_checker.sv
// ----------------------------------------------------------------------------
// mpps_checker: port-level checks for the motor position PID step
// Watches the channels over time and flags sequencing slips.
// ----------------------------------------------------------------------------
module mpps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mpps_pkg::MAGNITUDE_W-1:0] drive_magnitude,
  input logic                             in_deadband
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no drive inside the deadband
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_deadband |-> drive_magnitude == '0)
    else $error("nonzero drive in deadband");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motor_position_pid_step mpps_checker u_mpps_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .drive_magnitude (out_ch.drive_magnitude),
  .in_deadband     (out_ch.in_deadband)
);
